// ===== hdl/srr_pkg.sv =====
// Shared types, constants and register map of the shift-reduce recognizer.
`timescale 1ns / 1ps
package srr_pkg;

  // Default sizes
  localparam int DEF_STACK_DEPTH    = 64;
  localparam int DEF_MAX_RULES      = 7;
  localparam int DEF_MAX_RIGHT      = 6;
  localparam int DEF_MAX_REDUCTIONS = 32;

  // Fixed field widths
  localparam int SYM_W      = 8;
  localparam int MODE_W     = 2;
  localparam int ACT_W      = 3;
  localparam int RULE_IDX_W = 3;
  localparam int LEVEL_W    = 7;
  localparam int CNT_W      = 3;
  localparam int LEN_W      = 3;
  localparam int RULE_W     = 59;

  // Rule word layout
  localparam int LEFT_LSB  = 0;
  localparam int LEN_LSB   = 8;
  localparam int RIGHT_LSB = 11;

  // Configuration port
  localparam int PADDR_W   = 6;
  localparam int PDATA_W   = 64;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_RULE_COUNT = 3'd0;
  localparam int REG_RULE_WORD0 = 1;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_SHIFT        = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHIFT_FINISH = 2'd1;

  typedef enum logic [ACT_W-1:0] {
    ACT_SHIFT    = 3'd0,
    ACT_REDUCE   = 3'd1,
    ACT_ACCEPT   = 3'd2,
    ACT_REJECT   = 3'd3,
    ACT_OVERFLOW = 3'd4,
    ACT_LIMIT    = 3'd5
  } action_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SYM_W-1:0]  symbol;
  } sym_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]      action;
    logic [RULE_IDX_W-1:0] rule_index;
    logic [LEVEL_W-1:0]    stack_level;
    logic [SYM_W-1:0]      top_symbol;
    logic                  last;
  } act_item_t;

  // Controller to datapath
  typedef struct packed {
    logic                  shift;
    logic                  reduce;
    logic                  clear;
    logic                  emit;
    logic [ACT_W-1:0]      action;
    logic [RULE_IDX_W-1:0] rule_index;
    logic                  last;
  } srr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic                  full;
    logic                  hit;
    logic [RULE_IDX_W-1:0] rule;
    logic                  accept_ok;
    logic                  refill_busy;
    logic                  out_free;
  } srr_stat_t;

endpackage

// ===== hdl/srr_chan_if.sv =====
// Valid/ready channel interface carrying one item payload.
`timescale 1ns / 1ps
interface srr_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/srr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/srr_regs.sv =====
// APB register block holding the rule count and rule words.
`timescale 1ns / 1ps
module srr_regs import srr_pkg::*; #(
  parameter int MAX_RULES = DEF_MAX_RULES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CNT_W-1:0]   rule_count,
  output logic [RULE_W-1:0]  rule_words [MAX_RULES]
);
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  // registers sit on 8-byte boundaries
  assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count <= '0;
      for (int r = 0; r < MAX_RULES; r++) begin
        rule_words[r] <= '0;
      end
    end else if (wr_en) begin
      if (reg_idx == REG_RULE_COUNT) begin
        rule_count <= pwdata[CNT_W-1:0];
      end
      for (int r = 0; r < MAX_RULES; r++) begin
        if (reg_idx == REG_IDX_W'(REG_RULE_WORD0 + r)) begin
          rule_words[r] <= pwdata[RULE_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_RULE_COUNT) begin
      prdata = PDATA_W'(rule_count);
    end
    for (int r = 0; r < MAX_RULES; r++) begin
      if (reg_idx == REG_IDX_W'(REG_RULE_WORD0 + r)) begin
        prdata = PDATA_W'(rule_words[r]);
      end
    end
  end
endmodule

// ===== hdl/srr_ctrl.sv =====
// Sequencer: shift, greedy reduce loop, verdict and result ordering.
`timescale 1ns / 1ps
module srr_ctrl import srr_pkg::*; #(
  parameter int MAX_REDUCTIONS = DEF_MAX_REDUCTIONS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] in_mode,
  output srr_cmd_t          cmd,
  input  srr_stat_t         stat
);
  localparam int RW = $clog2(MAX_REDUCTIONS + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MATCH  = 4'b0010,
    ST_REFILL = 4'b0100,
    ST_LAST   = 4'b1000
  } state_t;

  state_t                state, state_next;
  logic                  finish_f, finish_f_next;
  logic [RW-1:0]         done, done_next;
  logic                  pend_valid, pend_valid_next;
  action_t               pend_action, pend_action_next;
  logic [RULE_IDX_W-1:0] pend_rule, pend_rule_next;
  logic                  item_shift;
  logic                  item_finish;

  assign in_ready    = (state == ST_IDLE);
  assign item_shift  = in_mode inside {MODE_SHIFT, MODE_SHIFT_FINISH};
  assign item_finish = (in_mode != MODE_SHIFT);

  always_comb begin
    state_next       = state;
    finish_f_next    = finish_f;
    done_next        = done;
    pend_valid_next  = pend_valid;
    pend_action_next = pend_action;
    pend_rule_next   = pend_rule;
    cmd              = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          finish_f_next    = item_finish;
          done_next        = '0;
          pend_valid_next  = item_shift;
          pend_action_next = stat.full ? ACT_OVERFLOW : ACT_SHIFT;
          pend_rule_next   = '0;
          cmd.shift        = item_shift;
          state_next       = ST_MATCH;
        end
      end
      ST_MATCH: begin
        // the previous result goes out now that we know whether more follow
        if (!pend_valid || stat.out_free) begin
          cmd.emit       = pend_valid;
          cmd.action     = pend_action;
          cmd.rule_index = pend_rule;
          cmd.last       = !stat.hit && !finish_f;
          pend_valid_next = 1'b0;
          if (stat.hit && (done < RW'(MAX_REDUCTIONS))) begin
            cmd.reduce       = 1'b1;
            pend_valid_next  = 1'b1;
            pend_action_next = ACT_REDUCE;
            pend_rule_next   = stat.rule;
            done_next        = done + 1'b1;
            state_next       = ST_REFILL;
          end else if (stat.hit) begin
            cmd.clear        = finish_f;
            pend_valid_next  = 1'b1;
            pend_action_next = ACT_LIMIT;
            pend_rule_next   = '0;
            state_next       = ST_LAST;
          end else if (finish_f) begin
            cmd.clear        = 1'b1;
            pend_valid_next  = 1'b1;
            pend_action_next = stat.accept_ok ? ACT_ACCEPT : ACT_REJECT;
            pend_rule_next   = '0;
            state_next       = ST_LAST;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_REFILL: begin
        if (!stat.refill_busy) begin
          state_next = ST_MATCH;
        end
      end
      ST_LAST: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.action      = pend_action;
          cmd.rule_index  = pend_rule;
          cmd.last        = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      finish_f    <= 1'b0;
      done        <= '0;
      pend_valid  <= 1'b0;
      pend_action <= ACT_SHIFT;
      pend_rule   <= '0;
    end else begin
      state       <= state_next;
      finish_f    <= finish_f_next;
      done        <= done_next;
      pend_valid  <= pend_valid_next;
      pend_action <= pend_action_next;
      pend_rule   <= pend_rule_next;
    end
  end
endmodule

// ===== hdl/srr_dpath.sv =====
// Datapath: symbol stack memory, top-of-stack window, rule matcher, result register.
`timescale 1ns / 1ps
module srr_dpath import srr_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int MAX_RULES   = DEF_MAX_RULES,
  parameter int MAX_RIGHT   = DEF_MAX_RIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  srr_cmd_t          cmd,
  output srr_stat_t         stat,
  input  logic [SYM_W-1:0]  symbol,
  input  logic [CNT_W-1:0]  rule_count,
  input  logic [RULE_W-1:0] rule_words [MAX_RULES],
  output logic              out_valid,
  input  logic              out_ready,
  output act_item_t         out_data
);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int SW = (MAX_RIGHT > 1) ? $clog2(MAX_RIGHT) : 1;

  logic [CW-1:0]         count;
  // window[MAX_RIGHT-1] mirrors the stack top, lower slots go deeper
  logic [SYM_W-1:0]      window [MAX_RIGHT];
  logic [LEN_W-1:0]      rf_need;
  logic [LEN_W-1:0]      rf_issue;
  logic                  cap_v;
  logic [SW-1:0]         cap_slot;

  logic [CNT_W-1:0]      n_used;
  logic [LEN_W-1:0]      rlen [MAX_RULES];
  logic [MAX_RULES-1:0]  hits;
  logic                  hit;
  logic [RULE_IDX_W-1:0] hit_rule;
  logic [LEN_W-1:0]      hit_len;
  logic [SYM_W-1:0]      hit_left;
  logic                  full;
  logic                  push;
  logic [SYM_W-1:0]      top_sym;
  logic [CW-1:0]         rd_off;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [SYM_W-1:0]      ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [SYM_W-1:0]      ram_rdata;

  assign n_used  = (int'(rule_count) > MAX_RULES) ? CNT_W'(MAX_RULES) : rule_count;
  assign full    = (count == CW'(STACK_DEPTH));
  assign push    = cmd.shift && !full;
  assign top_sym = (count != '0) ? window[MAX_RIGHT-1] : '0;

  // Every rule is checked against the window at once; lowest index wins.
  always_comb begin
    for (int r = 0; r < MAX_RULES; r++) begin
      rlen[r] = rule_words[r][LEN_LSB +: LEN_W];
      hits[r] = (r < int'(n_used)) && (rlen[r] != '0) && (int'(rlen[r]) <= MAX_RIGHT)
                && (CW'(rlen[r]) <= count);
      for (int i = 0; i < MAX_RIGHT; i++) begin
        if ((i < int'(rlen[r])) && (int'(rlen[r]) <= MAX_RIGHT)) begin
          if (window[MAX_RIGHT - int'(rlen[r]) + i] !=
              rule_words[r][RIGHT_LSB + SYM_W * i +: SYM_W]) begin
            hits[r] = 1'b0;
          end
        end
      end
    end
    hit      = 1'b0;
    hit_rule = '0;
    hit_len  = '0;
    hit_left = '0;
    for (int r = MAX_RULES - 1; r >= 0; r--) begin
      if (hits[r]) begin
        hit      = 1'b1;
        hit_rule = RULE_IDX_W'(r);
        hit_len  = rlen[r];
        hit_left = rule_words[r][LEFT_LSB +: SYM_W];
      end
    end
  end

  always_comb begin
    stat.full        = full;
    stat.hit         = hit;
    stat.rule        = hit_rule;
    stat.accept_ok   = (n_used != '0) && (count == CW'(1)) &&
                       (window[MAX_RIGHT-1] == rule_words[0][LEFT_LSB +: SYM_W]);
    stat.refill_busy = (rf_issue < rf_need) || cap_v;
    stat.out_free    = !out_valid || out_ready;
  end

  // Stack memory: write on push or reduce, read while refilling the window.
  // Slot s of the window holds stack entry count - MAX_RIGHT + s.
  always_comb begin
    ram_we    = push || cmd.reduce;
    ram_waddr = cmd.shift ? AW'(count) : AW'(count - CW'(hit_len));
    ram_wdata = cmd.shift ? symbol : hit_left;
    rd_off    = CW'(MAX_RIGHT) - CW'(rf_issue);
    ram_raddr = (count >= rd_off) ? AW'(count - rd_off) : '0;
  end

  srr_ram #(
    .WIDTH (SYM_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rf_need   <= '0;
      rf_issue  <= '0;
      cap_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cap_v <= 1'b0;
      if (rf_issue < rf_need) begin
        rf_issue <= rf_issue + 1'b1;
        cap_v    <= 1'b1;
      end
      if (cmd.clear) begin
        count <= '0;
      end else if (push) begin
        count <= count + 1'b1;
      end else if (cmd.reduce) begin
        // a reduce of length L exposes L-1 deeper entries to reload
        count    <= count - CW'(hit_len) + 1'b1;
        rf_need  <= hit_len - 1'b1;
        rf_issue <= '0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cap_slot <= SW'(rf_issue);
    if (cap_v) begin
      window[cap_slot] <= ram_rdata;
    end
    if (push) begin
      for (int s = 0; s < MAX_RIGHT - 1; s++) begin
        window[s] <= window[s+1];
      end
      window[MAX_RIGHT-1] <= symbol;
    end else if (cmd.reduce) begin
      for (int s = 0; s < MAX_RIGHT - 1; s++) begin
        if (s >= int'(hit_len) - 1) begin
          window[s] <= window[s - int'(hit_len) + 1];
        end
      end
      window[MAX_RIGHT-1] <= hit_left;
    end
    if (cmd.emit) begin
      out_data.action      <= cmd.action;
      out_data.rule_index  <= cmd.rule_index;
      out_data.stack_level <= LEVEL_W'(count);
      out_data.top_symbol  <= top_sym;
      out_data.last        <= cmd.last;
    end
  end
endmodule

// ===== hdl/shift_reduce_recognizer_core.sv =====
// Top level of the greedy shift-reduce recognizer.
// Usage:
//   symbols: one item per input, {mode, symbol}. Mode 0 pushes the symbol, mode 1
//   pushes it and then ends the input, modes 2 and 3 end the input without a push.
//   actions: one or more result items per input item, in order: a shift (or
//   stack overflow) if the item pushes, one reduce per applied rule, then the
//   verdict or reduce limit. The last result of an item has last set.
//   APB port: rule_count at 0x00, rule words 0..6 at 0x08..0x38, 64-bit data.
//   Write only while the block is idle (not enforced here). pready is tied high.
// Timing: an item is taken when the block is idle; one item is worked on at a
//   time. The shift result is issued from the match state once the output
//   register is free. Each reduce with right side length L reloads L-1 window
//   slots from the stack RAM, one read per cycle, before the next match.
//   A finishing item ends with the verdict, issued from the last-result state.
// Reset clears the stack count, the rule registers and all handshake state.
// When the receiver stalls the result stays in the output register and the
// sequencer waits with the next result; nothing is dropped.
`timescale 1ns / 1ps
module shift_reduce_recognizer_core import srr_pkg::*; #(
  parameter int STACK_DEPTH    = DEF_STACK_DEPTH,
  parameter int MAX_RULES      = DEF_MAX_RULES,
  parameter int MAX_RIGHT      = DEF_MAX_RIGHT,
  parameter int MAX_REDUCTIONS = DEF_MAX_REDUCTIONS
) (
  input  logic               clk,
  input  logic               rst,
  srr_chan_if.sink           symbols,
  srr_chan_if.source         actions,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);
  srr_cmd_t          cmd;
  srr_stat_t         stat;
  logic [CNT_W-1:0]  rule_count;
  logic [RULE_W-1:0] rule_words [MAX_RULES];
  act_item_t         out_item;
  logic              out_valid;

  srr_regs #(
    .MAX_RULES (MAX_RULES)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .rule_count (rule_count),
    .rule_words (rule_words)
  );

  srr_ctrl #(
    .MAX_REDUCTIONS (MAX_REDUCTIONS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (symbols.valid),
    .in_ready (symbols.ready),
    .in_mode  (symbols.data.mode),
    .cmd      (cmd),
    .stat     (stat)
  );

  srr_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_RULES   (MAX_RULES),
    .MAX_RIGHT   (MAX_RIGHT)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .symbol     (symbols.data.symbol),
    .rule_count (rule_count),
    .rule_words (rule_words),
    .out_valid  (out_valid),
    .out_ready  (actions.ready),
    .out_data   (out_item)
  );

  assign actions.valid = out_valid;
  assign actions.data  = out_item;

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result issued while output register still held an item");

  a_reduce_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.reduce |-> stat.hit)
    else $error("reduce issued without a matching rule");

  a_one_update: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.shift, cmd.reduce, cmd.clear}))
    else $error("conflicting stack updates in one cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (symbols.valid && symbols.ready) |=> !symbols.ready)
    else $error("input taken again right after an accept");
endmodule
